### hdl/blbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blbd_pkg
// shared types, register codes and generator constants for the line blanking
// and dither block
// ----------------------------------------------------------------------------
package blbd_pkg;

	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 16;
	localparam int GEN_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0] GEN_MULT = 16'd36969;
	localparam logic [GEN_W-1:0] GEN_SEED = 32'd362436069;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_BYTES   = 3'd0,
		REG_HEADER_BYTES = 3'd1,
		REG_LINE_PERIOD  = 3'd2,
		REG_BURST_LINES  = 3'd3,
		REG_START_PHASE  = 3'd4,
		REG_FILL_BASE    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic replace;
		logic line_end;
	} ctrl_t;

	// one multiply-with-carry step, kept in 32 bits
	function automatic logic [GEN_W-1:0] gen_advance(input logic [GEN_W-1:0] w);
		logic [GEN_W-1:0] prod;
		prod = GEN_W'(GEN_MULT) * GEN_W'(w[CNT_W-1:0]);
		return prod + GEN_W'(w[GEN_W-1:CNT_W]);
	endfunction

endpackage
`default_nettype wire

### hdl/blbd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blbd_ctrl
// configuration registers, byte position and line phase counters, and the
// per-byte replace and line end decisions
// ----------------------------------------------------------------------------
module blbd_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [blbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [blbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              step,
	output blbd_pkg::ctrl_t                        flags,
	output logic      [blbd_pkg::BYTE_W-1:0]       fill_base
);
	import blbd_pkg::*;

	logic [CNT_W-1:0] line_bytes_q;
	logic [CNT_W-1:0] header_bytes_q;
	logic [CNT_W-1:0] line_period_q;
	logic [CNT_W-1:0] burst_lines_q;
	logic [BYTE_W-1:0] fill_base_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] phase_q;

	logic [CNT_W:0] pos_inc;
	logic [CNT_W:0] phase_inc;
	logic           phase_wrap;

	assign pos_inc    = {1'b0, pos_q} + (CNT_W+1)'(1);
	assign phase_inc  = {1'b0, phase_q} + (CNT_W+1)'(1);
	assign phase_wrap = phase_inc >= {1'b0, line_period_q};

	assign flags.replace  = (pos_q >= header_bytes_q) && (phase_q > burst_lines_q);
	assign flags.line_end = pos_inc >= {1'b0, line_bytes_q};
	assign fill_base      = fill_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q   <= CNT_W'(1);
			header_bytes_q <= '0;
			line_period_q  <= CNT_W'(1);
			burst_lines_q  <= '0;
			fill_base_q    <= '0;
			pos_q          <= '0;
			phase_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LINE_BYTES:   line_bytes_q   <= cfg_data;
				REG_HEADER_BYTES: header_bytes_q <= cfg_data;
				REG_LINE_PERIOD:  line_period_q  <= cfg_data;
				REG_BURST_LINES:  burst_lines_q  <= cfg_data;
				REG_START_PHASE:  phase_q        <= cfg_data;
				REG_FILL_BASE:    fill_base_q    <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end else if (step) begin
			if (flags.line_end) begin
				pos_q   <= '0;
				phase_q <= phase_wrap ? '0 : phase_inc[CNT_W-1:0];
			end else begin
				pos_q <= pos_inc[CNT_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

### hdl/blbd_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blbd_gen
// multiply-with-carry generator, holds the word that the next replaced byte
// uses so the multiply stays off the byte path
// ----------------------------------------------------------------------------
module blbd_gen (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	output logic [blbd_pkg::BYTE_W-1:0]        dither
);
	import blbd_pkg::*;

	logic [GEN_W-1:0] word_q;

	// even word gives 0, odd word gives +1 or -1 by its sign bit
	assign dither = !word_q[0] ? '0 : (word_q[GEN_W-1] ? '1 : BYTE_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= gen_advance(GEN_SEED);
		end else if (step) begin
			word_q <= gen_advance(word_q);
		end
	end

endmodule
`default_nettype wire

### hdl/burst_line_blanking_dither.sv
`default_nettype none
// ----------------------------------------------------------------------------
// burst_line_blanking_dither
// passes radar line bytes, replacing sample bytes of blanked lines with a
// dithered fill value
// the input byte is registered in data_s1, then the output byte, replace and
// line end flags in data_s2, repl_s2 and last_s2, which drive the output
// throughput: one byte per cycle unless the output stalls, set by counter and
// generator update; a stalled output holds the input off once both stages fill
// reset clears valids, counters, registers to defaults and reseeds the generator
// ----------------------------------------------------------------------------
module burst_line_blanking_dither (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [blbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [blbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,   // data_byte
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [7:0]                        m_tdata,   // out_byte
	output logic                                   m_tuser,   // replaced
	output logic                                   m_tlast    // line_end
);
	import blbd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              valid_s2;
	logic [BYTE_W-1:0] data_s2;
	logic              repl_s2;
	logic              last_s2;

	logic              adv;
	logic              take;
	ctrl_t             flags;
	logic [BYTE_W-1:0] fill_base;
	logic [BYTE_W-1:0] dither;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;

	blbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (adv),
		.flags     (flags),
		.fill_base (fill_base)
	);

	blbd_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv && flags.replace),
		.dither (dither)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= s_tdata;
		end
		if (adv) begin
			data_s2 <= flags.replace ? BYTE_W'(fill_base + dither) : data_s1;
			repl_s2 <= flags.replace;
			last_s2 <= flags.line_end;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = repl_s2;
	assign m_tlast  = last_s2;

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the line blanking and dither block: a per-transfer
// predictor tracks line position, line phase and the multiply-with-carry word,
// and every output transfer is compared field by field against it while both
// stream sides idle at random, including a long receiver hold-off
// ----------------------------------------------------------------------------
module tb;
	import blbd_pkg::*;

	localparam logic [31:0]          MWC_MULT    = 32'd36969;
	localparam logic [31:0]          MWC_SEED    = 32'd362436069;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_6  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_7  = 3'd7;
	localparam int                   CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       replaced;
		logic       line_end;
	} blank_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	// predictor copy of registers and state
	logic [15:0] cfg_line_bytes;
	logic [15:0] cfg_header;
	logic [15:0] cfg_period;
	logic [15:0] cfg_burst;
	logic [15:0] cfg_start;
	logic [7:0]  cfg_fill;
	logic [15:0] pos_m;
	logic [15:0] phase_m;
	logic [31:0] mwc_word;

	blank_out_t out_due[$];
	int         errors      = 0;
	int         cycle_count = 0;
	int         hold_len    = 0;
	int         tx_streak   = 0;
	logic       full_rate   = 1'b0;

	burst_line_blanking_dither dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // data_byte
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // out_byte
		.m_tuser   (m_tuser),   // replaced
		.m_tlast   (m_tlast)    // line_end
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("burst_line_blanking_dither: mismatch");
		$finish;
	end

	function automatic void model_reset();
		cfg_line_bytes = 16'd1;
		cfg_header     = 16'd0;
		cfg_period     = 16'd1;
		cfg_burst      = 16'd0;
		cfg_start      = 16'd0;
		cfg_fill       = 8'd0;
		pos_m          = 16'd0;
		phase_m        = 16'd0;
		mwc_word       = MWC_SEED;
	endfunction

	function automatic blank_out_t blank_byte(input logic [7:0] data);
		blank_out_t r;
		r.out_byte = data;
		r.replaced = 1'b0;
		if (pos_m >= cfg_header && phase_m > cfg_burst) begin
			mwc_word = MWC_MULT * {16'd0, mwc_word[15:0]} + {16'd0, mwc_word[31:16]};
			r.replaced = 1'b1;
			if (!mwc_word[0])
				r.out_byte = cfg_fill;
			else if (mwc_word[31])
				r.out_byte = cfg_fill - 8'd1;
			else
				r.out_byte = cfg_fill + 8'd1;
		end
		r.line_end = ({16'd0, pos_m} + 32'd1 >= {16'd0, cfg_line_bytes});
		if (r.line_end) begin
			pos_m = 16'd0;
			if ({16'd0, phase_m} + 32'd1 >= {16'd0, cfg_period})
				phase_m = 16'd0;
			else
				phase_m = phase_m + 16'd1;
		end else begin
			pos_m = pos_m + 16'd1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 40)
			$display("cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
	endtask

	// input side: predict on each accepted transfer
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			out_due.push_back(blank_byte(s_tdata));
	end

	// output side: compare each accepted transfer with the oldest prediction
	always @(posedge clk) begin
		blank_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (out_due.size() == 0) begin
				report_mismatch("transfer with nothing due, out_byte", m_tdata, 0);
			end else begin
				want = out_due.pop_front();
				if (m_tdata !== want.out_byte)
					report_mismatch("out_byte", m_tdata, want.out_byte);
				if (m_tuser !== want.replaced)
					report_mismatch("replaced", m_tuser, want.replaced);
				if (m_tlast !== want.line_end)
					report_mismatch("line_end", m_tlast, want.line_end);
			end
		end
	end

	// receiver: random idle bursts, calm stretches, and a long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				m_tready = 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end else if (full_rate) begin
				m_tready = 1'b1;
			end else if ($urandom_range(0, 15) == 0) begin
				m_tready = 1'b1;
				repeat ($urandom_range(20, 40)) @(negedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b);
		if (!full_rate) begin
			if (tx_streak > 0) begin
				tx_streak--;
			end else if ($urandom_range(0, 11) == 0) begin
				tx_streak = $urandom_range(10, 30);
			end else if ($urandom_range(0, 3) == 0) begin
				s_tvalid = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (out_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		case (idx)
			REG_LINE_BYTES:   cfg_line_bytes = val;
			REG_HEADER_BYTES: cfg_header     = val;
			REG_LINE_PERIOD:  cfg_period     = val;
			REG_BURST_LINES:  cfg_burst      = val;
			REG_START_PHASE: begin
				cfg_start = val;
				phase_m   = val;
			end
			REG_FILL_BASE:    cfg_fill       = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic setup(input logic [15:0] lb, input logic [15:0] hb, input logic [15:0] per,
			input logic [15:0] bl, input logic [15:0] sp, input logic [15:0] fb);
		write_reg(REG_LINE_BYTES, lb);
		write_reg(REG_HEADER_BYTES, hb);
		write_reg(REG_LINE_PERIOD, per);
		write_reg(REG_BURST_LINES, bl);
		write_reg(REG_START_PHASE, sp);
		write_reg(REG_FILL_BASE, fb);
	endtask

	task automatic test_reset_defaults();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		drain();
	endtask

	task automatic test_blank_lines();
		// fill 0 with a positive dither gives 01
		setup(16'd2, 16'd1, 16'd3, 16'd0, 16'd0, 16'd0);
		for (int i = 0; i < 6; i++)
			send_byte(8'(i * 53 + 7));
		drain();
		// fill ff with a positive dither wraps to 00, upper data bits ignored
		setup(16'd2, 16'd0, 16'd3, 16'd0, 16'd1, 16'hABFF);
		for (int i = 0; i < 4; i++)
			send_byte(8'(8'h5A ^ i));
		drain();
	endtask

	task automatic test_corner_lengths();
		// zero line length, zero period, start phase past the period
		setup(16'd0, 16'd0, 16'd0, 16'd3, 16'd5, 16'h007F);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		drain();
		// header as long as the line
		setup(16'd3, 16'd3, 16'd2, 16'd0, 16'd1, 16'h0040);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'hFE);
		drain();
		// register extremes
		setup(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65534, 16'h00FF);
		send_byte(8'hC3);
		drain();
	endtask

	task automatic test_midline_length();
		setup(16'd5, 16'd0, 16'd2, 16'd0, 16'd1, 16'h0010);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		drain();
		// position already past the new length, next byte ends the line
		write_reg(REG_LINE_BYTES, 16'd2);
		send_byte(8'h04);
		send_byte(8'h05);
		drain();
	endtask

	task automatic test_unused_index();
		write_reg(REG_NONE_6, 16'h0000);
		write_reg(REG_NONE_7, 16'hFFFF);
		send_byte(8'h6C);
		send_byte(8'h93);
		drain();
	endtask

	task automatic random_setup();
		logic [15:0] lb;
		logic [15:0] hb;
		logic [15:0] per;
		logic [15:0] bl;
		logic [15:0] sp;
		logic [15:0] fb;
		case ($urandom_range(0, 9))
			0:       lb = 16'd0;
			1:       lb = 16'd65535;
			default: lb = 16'($urandom_range(1, 12));
		endcase
		hb  = ($urandom_range(0, 9) == 0) ? 16'd65535 : 16'($urandom_range(0, 14));
		case ($urandom_range(0, 9))
			0:       per = 16'd0;
			1:       per = 16'd65535;
			default: per = 16'($urandom_range(1, 6));
		endcase
		bl  = ($urandom_range(0, 9) == 0) ? 16'd65535 : 16'($urandom_range(0, 3));
		sp  = ($urandom_range(0, 9) == 0) ? 16'd65534 : 16'($urandom_range(0, 8));
		fb  = 16'($urandom_range(0, 65535));
		write_reg(REG_LINE_BYTES, lb);
		write_reg(REG_HEADER_BYTES, hb);
		write_reg(REG_LINE_PERIOD, per);
		write_reg(REG_BURST_LINES, bl);
		// sometimes the line phase carries over from the previous setting
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_START_PHASE, sp);
		write_reg(REG_FILL_BASE, fb);
		if ($urandom_range(0, 7) == 0)
			write_reg(($urandom_range(0, 1) == 0) ? REG_NONE_6 : REG_NONE_7,
				16'($urandom_range(0, 65535)));
	endtask

	task automatic test_random_setups();
		repeat (13) begin
			random_setup();
			repeat ($urandom_range(50, 70))
				send_byte(8'($urandom_range(0, 255)));
			drain();
		end
	endtask

	task automatic test_backpressure();
		setup(16'd4, 16'd1, 16'd3, 16'd0, 16'd1, 16'h0080);
		hold_len = 80;
		repeat (40)
			send_byte(8'($urandom_range(0, 255)));
		drain();
	endtask

	task automatic test_full_rate();
		setup(16'd5, 16'd2, 16'd4, 16'd1, 16'd0, 16'($urandom_range(0, 255)));
		full_rate = 1'b1;
		repeat (60)
			send_byte(8'($urandom_range(0, 255)));
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'd0;
		model_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_blank_lines();
		test_corner_lengths();
		test_midline_length();
		test_unused_index();
		test_random_setups();
		test_backpressure();
		test_full_rate();

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && out_due.size() == 0)
			$display("burst_line_blanking_dither: match");
		else
			$display("burst_line_blanking_dither: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
hdl/blbd_pkg.sv
hdl/blbd_ctrl.sv
hdl/blbd_gen.sv
hdl/burst_line_blanking_dither.sv
tb/tb.sv
